// File: rtl/sm83s_pkg.sv
// Package: opcodes, post-boot register values and flag positions of the SM83 subset step.
`timescale 1ns / 1ps
package sm83s_pkg;

    // Opcodes of the supported subset
    localparam logic [7:0] OP_NOP     = 8'h00;
    localparam logic [7:0] OP_JP_A16  = 8'hC3;
    localparam logic [7:0] OP_XOR_A   = 8'hAF;
    localparam logic [7:0] OP_LD_HL   = 8'h21;
    localparam logic [7:0] OP_LD_SP   = 8'h31;
    localparam logic [7:0] OP_LD_A    = 8'h3E;
    localparam logic [7:0] OP_LD_B    = 8'h06;
    localparam logic [7:0] OP_LD_C    = 8'h0E;
    localparam logic [7:0] OP_LDD_HLA = 8'h32;
    localparam logic [7:0] OP_DEC_B   = 8'h05;
    localparam logic [7:0] OP_DEC_C   = 8'h0D;
    localparam logic [7:0] OP_JR_NZ   = 8'h20;
    localparam logic [7:0] OP_DI      = 8'hF3;
    localparam logic [7:0] OP_EI      = 8'hFB;

    // Machine clock counts
    localparam logic [4:0] CYC_NONE = 5'd0;
    localparam logic [4:0] CYC_4    = 5'd4;
    localparam logic [4:0] CYC_8    = 5'd8;
    localparam logic [4:0] CYC_12   = 5'd12;
    localparam logic [4:0] CYC_16   = 5'd16;

    // Flag nibble bit positions: Z N H C
    localparam int FLAG_Z = 3;
    localparam int FLAG_N = 2;
    localparam int FLAG_H = 1;
    localparam int FLAG_C = 0;

    // Post-boot register values
    localparam logic [15:0] RST_PC    = 16'h0100;
    localparam logic [15:0] RST_SP    = 16'hFFFE;
    localparam logic [7:0]  RST_A     = 8'h01;
    localparam logic [3:0]  RST_FLAGS = 4'hB;
    localparam logic [7:0]  RST_B     = 8'h00;
    localparam logic [7:0]  RST_C     = 8'h13;
    localparam logic [7:0]  RST_H     = 8'h01;
    localparam logic [7:0]  RST_L     = 8'h4D;

    typedef struct packed {
        logic [15:0] next_pc;
        logic [4:0]  cycles;
        logic        write_en;
        logic [15:0] write_addr;
        logic [7:0]  write_data;
        logic        illegal;
        logic [7:0]  acc;
        logic [3:0]  flag_bits;
        logic        interrupts_enabled;
        logic [15:0] bc_pair;
        logic [15:0] hl_pair;
        logic [15:0] stack_ptr;
    } t_result;

endpackage

// File: rtl/sm83_instruction_subset_step.sv
// Top level: executes one SM83 subset instruction per input beat, one result beat each.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | into      | i_valid / o_stall  | i_func, i_operand_word
//  out     | out of    | o_valid / i_stall  | o_next_pc ... o_stack_ptr (12 fields)
//
// Flow: a beat taken into the input register is executed from there and loaded into the
// result register when that register is free; one beat per cycle is sustained while the
// output is not stalled. The register file updates on the edge that loads the result, so
// the next beat always sees the state left by the one before it.
// Reset (synchronous, active low) loads the post-boot register values and empties
// both stages. A stall on the output holds the result and backs up into o_stall.
`timescale 1ns / 1ps
`default_nettype none
module sm83_instruction_subset_step (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_func,
    input  wire logic [15:0] i_operand_word,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [15:0]      o_next_pc,
    output logic [4:0]       o_cycles,
    output logic             o_write_en,
    output logic [15:0]      o_write_addr,
    output logic [7:0]       o_write_data,
    output logic             o_illegal,
    output logic [7:0]       o_acc,
    output logic [3:0]       o_flag_bits,
    output logic             o_interrupts_enabled,
    output logic [15:0]      o_bc_pair,
    output logic [15:0]      o_hl_pair,
    output logic [15:0]      o_stack_ptr
);
    import sm83s_pkg::*;

    // Input stage
    logic        r_in_valid;
    logic [7:0]  r_func;
    logic [15:0] r_word;

    // Architectural registers
    logic [15:0] r_pc, n_pc;
    logic [15:0] r_sp, n_sp;
    logic [7:0]  r_a, n_a;
    logic [3:0]  r_f, n_f;
    logic [7:0]  r_b, n_b;
    logic [7:0]  r_c, n_c;
    logic [7:0]  r_h, n_h;
    logic [7:0]  r_l, n_l;
    logic        r_ime, n_ime;

    // Result stage
    logic        r_out_valid;
    t_result     r_res, n_res;

    logic        out_load;   // result register may take a new beat
    logic        exec;       // input stage retires into the result register
    logic [15:0] pc_inc;
    logic [15:0] hl_cur;
    logic [15:0] hl_dec;
    logic [7:0]  dec_in;
    logic [7:0]  dec_out;
    logic [3:0]  dec_flags;
    logic [15:0] rel_off;

    // Output register is free when empty or being drained this cycle
    assign out_load = !r_out_valid || !i_stall;
    assign exec     = r_in_valid && out_load;
    // Input register takes a beat when empty or when its beat retires now
    assign o_stall  = r_in_valid && !out_load;

    assign pc_inc  = r_pc + 16'd1;
    assign hl_cur  = {r_h, r_l};
    assign hl_dec  = hl_cur - 16'd1;
    assign rel_off = {{8{r_word[7]}}, r_word[7:0]};

    // Shared 8-bit decrement for DEC B and DEC C; carry is kept
    assign dec_in  = (r_func == OP_DEC_C) ? r_c : r_b;
    assign dec_out = dec_in - 8'd1;
    always_comb begin
        dec_flags         = 4'b0000;
        dec_flags[FLAG_Z] = (dec_out == 8'h00);
        dec_flags[FLAG_N] = 1'b1;
        dec_flags[FLAG_H] = (dec_in[3:0] == 4'h0);
        dec_flags[FLAG_C] = r_f[FLAG_C];
    end

    // Decode and execute the held instruction
    always_comb begin
        n_pc  = pc_inc;
        n_sp  = r_sp;
        n_a   = r_a;
        n_f   = r_f;
        n_b   = r_b;
        n_c   = r_c;
        n_h   = r_h;
        n_l   = r_l;
        n_ime = r_ime;

        n_res            = '0;
        n_res.write_en   = 1'b0;
        n_res.write_addr = 16'h0000;
        n_res.write_data = 8'h00;
        n_res.illegal    = 1'b0;
        n_res.cycles     = CYC_4;

        case (r_func)
            OP_NOP: begin
                n_res.cycles = CYC_4;
            end
            OP_JP_A16: begin
                n_pc         = r_word;
                n_res.cycles = CYC_16;
            end
            OP_XOR_A: begin
                n_a          = 8'h00;
                n_f          = 4'b0000;
                n_f[FLAG_Z]  = 1'b1;
                n_res.cycles = CYC_4;
            end
            OP_LD_HL: begin
                n_h          = r_word[15:8];
                n_l          = r_word[7:0];
                n_pc         = r_pc + 16'd3;
                n_res.cycles = CYC_12;
            end
            OP_LD_SP: begin
                n_sp         = r_word;
                n_pc         = r_pc + 16'd3;
                n_res.cycles = CYC_12;
            end
            OP_LD_A: begin
                n_a          = r_word[7:0];
                n_pc         = r_pc + 16'd2;
                n_res.cycles = CYC_8;
            end
            OP_LD_B: begin
                n_b          = r_word[7:0];
                n_pc         = r_pc + 16'd2;
                n_res.cycles = CYC_8;
            end
            OP_LD_C: begin
                n_c          = r_word[7:0];
                n_pc         = r_pc + 16'd2;
                n_res.cycles = CYC_8;
            end
            OP_LDD_HLA: begin
                // Store A at HL, then post-decrement HL
                n_res.write_en   = 1'b1;
                n_res.write_addr = hl_cur;
                n_res.write_data = r_a;
                n_h              = hl_dec[15:8];
                n_l              = hl_dec[7:0];
                n_res.cycles     = CYC_8;
            end
            OP_DEC_B: begin
                n_b          = dec_out;
                n_f          = dec_flags;
                n_res.cycles = CYC_4;
            end
            OP_DEC_C: begin
                n_c          = dec_out;
                n_f          = dec_flags;
                n_res.cycles = CYC_4;
            end
            OP_JR_NZ: begin
                if (!r_f[FLAG_Z]) begin
                    n_pc         = r_pc + 16'd2 + rel_off;
                    n_res.cycles = CYC_12;
                end else begin
                    n_pc         = r_pc + 16'd2;
                    n_res.cycles = CYC_8;
                end
            end
            OP_DI: begin
                n_ime        = 1'b0;
                n_res.cycles = CYC_4;
            end
            OP_EI: begin
                n_ime        = 1'b1;
                n_res.cycles = CYC_4;
            end
            default: begin
                // Unknown opcode: hold every register, report illegal
                n_pc          = r_pc;
                n_res.illegal = 1'b1;
                n_res.cycles  = CYC_NONE;
            end
        endcase

        n_res.next_pc            = n_pc;
        n_res.acc                = n_a;
        n_res.flag_bits          = n_f;
        n_res.interrupts_enabled = n_ime;
        n_res.bc_pair            = {n_b, n_c};
        n_res.hl_pair            = {n_h, n_l};
        n_res.stack_ptr          = n_sp;
    end

    // Input stage: capture a beat whenever it is not stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall && i_valid) begin
            r_func <= i_func;
            r_word <= i_operand_word;
        end
    end

    // Register file: advance only when an instruction retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= RST_PC;
            r_sp  <= RST_SP;
            r_a   <= RST_A;
            r_f   <= RST_FLAGS;
            r_b   <= RST_B;
            r_c   <= RST_C;
            r_h   <= RST_H;
            r_l   <= RST_L;
            r_ime <= 1'b0;
        end else if (exec) begin
            r_pc  <= n_pc;
            r_sp  <= n_sp;
            r_a   <= n_a;
            r_f   <= n_f;
            r_b   <= n_b;
            r_c   <= n_c;
            r_h   <= n_h;
            r_l   <= n_l;
            r_ime <= n_ime;
        end
    end

    // Result stage: hold while stalled, load or drain otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec) begin
            r_res <= n_res;
        end
    end

    assign o_valid              = r_out_valid;
    assign o_next_pc            = r_res.next_pc;
    assign o_cycles             = r_res.cycles;
    assign o_write_en           = r_res.write_en;
    assign o_write_addr         = r_res.write_addr;
    assign o_write_data         = r_res.write_data;
    assign o_illegal            = r_res.illegal;
    assign o_acc                = r_res.acc;
    assign o_flag_bits          = r_res.flag_bits;
    assign o_interrupts_enabled = r_res.interrupts_enabled;
    assign o_bc_pair            = r_res.bc_pair;
    assign o_hl_pair            = r_res.hl_pair;
    assign o_stack_ptr          = r_res.stack_ptr;

endmodule
`default_nettype wire

// File: rtl/sm83s_checker.sv
// Checker: port-level assertions for the SM83 subset step, bound to the top level.
`timescale 1ns / 1ps
module sm83s_port_asserts (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [15:0] o_next_pc,
    input logic [4:0]  o_cycles,
    input logic        o_write_en,
    input logic [15:0] o_write_addr,
    input logic        o_illegal
);
    import sm83s_pkg::*;

    // Empty after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat shown right after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_pc) && $stable(o_write_addr))
        else $error("stalled result beat changed");

    // An illegal opcode takes no time and stores nothing
    a_illegal_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_illegal |-> o_cycles == CYC_NONE && !o_write_en)
        else $error("illegal beat with cycles or store");

    // Legal beats report one of the package's nonzero cycle counts
    a_cycles_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_illegal |-> o_cycles == CYC_4 || o_cycles == CYC_8
                                  || o_cycles == CYC_12 || o_cycles == CYC_16)
        else $error("legal beat with odd cycle count");

    // The only store is LD (HL-),A; a store beat is legal and reports that instruction's cycle count
    a_store_cycles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_write_en |-> o_cycles == CYC_8 && !o_illegal)
        else $error("store beat with wrong cycle count");

endmodule

bind sm83_instruction_subset_step sm83s_port_asserts u_sm83s_port_asserts (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_next_pc    (o_next_pc),
    .o_cycles     (o_cycles),
    .o_write_en   (o_write_en),
    .o_write_addr (o_write_addr),
    .o_illegal    (o_illegal)
);

// File: bench/sm83s_checker.sv
`timescale 1ns / 1ps
// Scoreboard: predicts each SM83 subset instruction and checks the result beats against it.
module sm83s_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_in_func,
    input  wire logic [15:0] i_in_word,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [15:0] i_next_pc,
    input  wire logic [4:0]  i_cycles,
    input  wire logic        i_write_en,
    input  wire logic [15:0] i_write_addr,
    input  wire logic [7:0]  i_write_data,
    input  wire logic        i_illegal,
    input  wire logic [7:0]  i_acc,
    input  wire logic [3:0]  i_flag_bits,
    input  wire logic        i_interrupts_enabled,
    input  wire logic [15:0] i_bc_pair,
    input  wire logic [15:0] i_hl_pair,
    input  wire logic [15:0] i_stack_ptr,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_checked
);
    import sm83s_pkg::*;

    // Shadow register file of the core
    logic [15:0] pc_q;
    logic [15:0] sp_q;
    logic [7:0]  a_q;
    logic [3:0]  flags_q;
    logic [7:0]  b_q;
    logic [7:0]  c_q;
    logic [7:0]  h_q;
    logic [7:0]  l_q;
    logic        ime_q;

    t_result retire_queue[$];
    t_result oldest;
    int      errors  = 0;
    int      checked = 0;

    function automatic logic [7:0] decrement_with_flags(input logic [7:0] v);
        logic [7:0] res;
        logic [3:0] f;
        res         = v - 8'd1;
        f           = 4'b0000;
        f[FLAG_C]   = flags_q[FLAG_C];
        f[FLAG_H]   = (v[3:0] == 4'h0);
        f[FLAG_Z]   = (res == 8'h00);
        f[FLAG_N]   = 1'b1;
        flags_q     = f;
        return res;
    endfunction

    // Advance the shadow state by one instruction and return what the core should report.
    function automatic t_result execute_op(input logic [7:0] op, input logic [15:0] word);
        t_result     r;
        logic [15:0] pc;
        logic [15:0] hl;
        logic [7:0]  lo;
        logic        bad;
        logic [4:0]  cyc;
        r   = '0;
        lo  = word[7:0];
        pc  = pc_q + 16'd1;
        bad = 1'b0;
        cyc = CYC_NONE;
        case (op)
            OP_NOP:    cyc = CYC_4;
            OP_JP_A16: begin
                pc  = word;
                cyc = CYC_16;
            end
            OP_XOR_A: begin
                a_q     = 8'h00;
                flags_q = 4'b0000;
                flags_q[FLAG_Z] = 1'b1;
                cyc     = CYC_4;
            end
            OP_LD_HL: begin
                h_q = word[15:8];
                l_q = lo;
                pc  = pc + 16'd2;
                cyc = CYC_12;
            end
            OP_LD_SP: begin
                sp_q = word;
                pc   = pc + 16'd2;
                cyc  = CYC_12;
            end
            OP_LD_A: begin
                a_q = lo;
                pc  = pc + 16'd1;
                cyc = CYC_8;
            end
            OP_LD_B: begin
                b_q = lo;
                pc  = pc + 16'd1;
                cyc = CYC_8;
            end
            OP_LD_C: begin
                c_q = lo;
                pc  = pc + 16'd1;
                cyc = CYC_8;
            end
            OP_LDD_HLA: begin
                hl           = {h_q, l_q};
                r.write_en   = 1'b1;
                r.write_addr = hl;
                r.write_data = a_q;
                hl           = hl - 16'd1;
                h_q          = hl[15:8];
                l_q          = hl[7:0];
                cyc          = CYC_8;
            end
            OP_DEC_B: begin
                b_q = decrement_with_flags(b_q);
                cyc = CYC_4;
            end
            OP_DEC_C: begin
                c_q = decrement_with_flags(c_q);
                cyc = CYC_4;
            end
            OP_JR_NZ: begin
                pc = pc + 16'd1;
                if (!flags_q[FLAG_Z]) begin
                    pc  = pc + {{8{lo[7]}}, lo};
                    cyc = CYC_12;
                end else begin
                    cyc = CYC_8;
                end
            end
            OP_DI: begin
                ime_q = 1'b0;
                cyc   = CYC_4;
            end
            OP_EI: begin
                ime_q = 1'b1;
                cyc   = CYC_4;
            end
            default: begin
                bad = 1'b1;
                pc  = pc_q;
            end
        endcase
        pc_q                 = pc;
        r.next_pc            = pc_q;
        r.cycles             = cyc;
        r.illegal            = bad;
        r.acc                = a_q;
        r.flag_bits          = flags_q;
        r.interrupts_enabled = ime_q;
        r.bc_pair            = {b_q, c_q};
        r.hl_pair            = {h_q, l_q};
        r.stack_ptr          = sp_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pc_q    = RST_PC;
            sp_q    = RST_SP;
            a_q     = RST_A;
            flags_q = RST_FLAGS;
            b_q     = RST_B;
            c_q     = RST_C;
            h_q     = RST_H;
            l_q     = RST_L;
            ime_q   = 1'b0;
            retire_queue.delete();
        end else begin
            // Retire before predicting: a result never belongs to a beat taken on the same edge.
            if (i_out_valid && !i_out_stall) begin
                if (retire_queue.size() == 0) begin
                    $error("result beat with no instruction outstanding");
                    errors++;
                end else begin
                    oldest = retire_queue.pop_front();
                    check_field("next_pc", oldest.next_pc, i_next_pc);
                    check_field("cycles", 16'(oldest.cycles), 16'(i_cycles));
                    check_field("write_en", 16'(oldest.write_en), 16'(i_write_en));
                    check_field("write_addr", oldest.write_addr, i_write_addr);
                    check_field("write_data", 16'(oldest.write_data), 16'(i_write_data));
                    check_field("illegal", 16'(oldest.illegal), 16'(i_illegal));
                    check_field("acc", 16'(oldest.acc), 16'(i_acc));
                    check_field("flag_bits", 16'(oldest.flag_bits), 16'(i_flag_bits));
                    check_field("interrupts_enabled", 16'(oldest.interrupts_enabled),
                                16'(i_interrupts_enabled));
                    check_field("bc_pair", oldest.bc_pair, i_bc_pair);
                    check_field("hl_pair", oldest.hl_pair, i_hl_pair);
                    check_field("stack_ptr", oldest.stack_ptr, i_stack_ptr);
                    checked++;
                end
            end
            if (i_in_valid && !i_in_stall)
                retire_queue.push_back(execute_op(i_in_func, i_in_word));
        end
        o_pending    <= retire_queue.size();
        o_fail_count <= errors;
        o_checked    <= checked;
    end

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Testbench top: drives SM83 subset instruction beats into the core and gives the verdict.
module tb_top;
    import sm83s_pkg::*;

    // Opcodes outside the subset, used to hit the illegal path on purpose
    localparam logic [7:0] OP_LD_BC_N16 = 8'h01;
    localparam logic [7:0] OP_RST_38    = 8'hFF;

    localparam int RESET_CYCLES    = 8;
    localparam int RANDOM_ITEMS    = 1650;
    localparam int DIRECTED_ITEMS  = 25;
    localparam int PRESSURE_POINT  = 800;
    localparam int TAIL_CYCLES     = 8;
    // Longest legal quiet spell is a sender gap plus a receiver stall, each drawn by pick_gap.
    localparam int WATCHDOG_LIMIT  = 4000;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_valid        = 1'b0;
    logic [7:0]  i_func         = 8'h00;
    logic [15:0] i_operand_word = 16'h0000;
    logic        i_stall        = 1'b0;

    logic        o_stall;
    logic        o_valid;
    logic [15:0] o_next_pc;
    logic [4:0]  o_cycles;
    logic        o_write_en;
    logic [15:0] o_write_addr;
    logic [7:0]  o_write_data;
    logic        o_illegal;
    logic [7:0]  o_acc;
    logic [3:0]  o_flag_bits;
    logic        o_interrupts_enabled;
    logic [15:0] o_bc_pair;
    logic [15:0] o_hl_pair;
    logic [15:0] o_stack_ptr;

    int fail_count;
    int pending;
    int checked;

    int n_items       = 0;
    int n_unsupported = 0;
    int idle_cycles   = 0;
    bit calm          = 1'b0;   // when set, neither side idles

    // All fourteen opcodes of the subset, for random picks
    logic [7:0] subset_ops [14] = '{OP_NOP, OP_JP_A16, OP_XOR_A, OP_LD_HL, OP_LD_SP,
                                    OP_LD_A, OP_LD_B, OP_LD_C, OP_LDD_HLA, OP_DEC_B,
                                    OP_DEC_C, OP_JR_NZ, OP_DI, OP_EI};

    always #1 i_clk = ~i_clk;

    sm83_instruction_subset_step i_dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_func               (i_func),
        .i_operand_word       (i_operand_word),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_next_pc            (o_next_pc),
        .o_cycles             (o_cycles),
        .o_write_en           (o_write_en),
        .o_write_addr         (o_write_addr),
        .o_write_data         (o_write_data),
        .o_illegal            (o_illegal),
        .o_acc                (o_acc),
        .o_flag_bits          (o_flag_bits),
        .o_interrupts_enabled (o_interrupts_enabled),
        .o_bc_pair            (o_bc_pair),
        .o_hl_pair            (o_hl_pair),
        .o_stack_ptr          (o_stack_ptr)
    );

    sm83s_checker i_checker (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_valid),
        .i_in_stall           (o_stall),
        .i_in_func            (i_func),
        .i_in_word            (i_operand_word),
        .i_out_valid          (o_valid),
        .i_out_stall          (i_stall),
        .i_next_pc            (o_next_pc),
        .i_cycles             (o_cycles),
        .i_write_en           (o_write_en),
        .i_write_addr         (o_write_addr),
        .i_write_data         (o_write_data),
        .i_illegal            (o_illegal),
        .i_acc                (o_acc),
        .i_flag_bits          (o_flag_bits),
        .i_interrupts_enabled (o_interrupts_enabled),
        .i_bc_pair            (o_bc_pair),
        .i_hl_pair            (o_hl_pair),
        .i_stack_ptr          (o_stack_ptr),
        .o_fail_count         (fail_count),
        .o_pending            (pending),
        .o_checked            (checked)
    );

    // Gap length: mostly none, often a few cycles, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one instruction beat, hold it until taken, then idle for a random gap.
    // Valid stays high straight into the next beat when the gap is zero.
    task automatic issue(input logic [7:0] f, input logic [15:0] w);
        int gap;
        i_valid        <= 1'b1;
        i_func         <= f;
        i_operand_word <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        n_items++;
        case (f)
            OP_NOP, OP_JP_A16, OP_XOR_A, OP_LD_HL, OP_LD_SP, OP_LD_A, OP_LD_B,
            OP_LD_C, OP_LDD_HLA, OP_DEC_B, OP_DEC_C, OP_JR_NZ, OP_DI, OP_EI: ;
            default: n_unsupported++;
        endcase
        gap = calm ? 0 : pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop valid and hold off until the scoreboard has nothing outstanding.
    // The first edge lets the count pick up the beat taken on this edge.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
    endtask

    // Receiver: release the output most of the time, stall in random bursts.
    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                i_stall <= 1'b1;
                hold--;
            end else begin
                i_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    hold = pick_gap();
            end
        end
    end

    // Watchdog: end the run if neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Stimulus and verdict
    initial begin
        int          kind;
        int          bursts;
        logic [7:0]  cnt;
        logic [7:0]  hi8;
        logic [7:0]  ld_op;
        logic [7:0]  dec_op;
        logic [15:0] hl_start;
        bit          drained;
        drained = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. First beat reads back the post-boot register file.
        issue(OP_NOP, 16'hFFFF);
        issue(OP_RST_38, 16'h1234);        // outside the subset: nothing moves
        issue(OP_LD_BC_N16, 16'h0000);     // outside the subset
        issue(OP_JR_NZ, 16'h0005);         // Z set after boot: not taken
        issue(OP_DEC_B, 16'hFFFF);         // 00 -> FF: half borrow, carry kept
        issue(OP_JR_NZ, 16'h0080);         // taken, most negative offset
        issue(OP_JR_NZ, 16'hFF7F);         // taken, most positive offset
        issue(OP_LD_B, 16'hFF01);
        issue(OP_DEC_B, 16'h0000);         // 01 -> 00: zero flag
        issue(OP_DEC_C, 16'hFFFF);
        issue(OP_LD_C, 16'h00F0);
        issue(OP_DEC_C, 16'h0000);         // low nibble zero: half borrow
        issue(OP_JP_A16, 16'hFFFF);
        issue(OP_NOP, 16'h0000);           // program counter wraps to 0000
        issue(OP_LD_HL, 16'h0000);
        issue(OP_LD_A, 16'hFFA5);
        issue(OP_LDD_HLA, 16'hFFFF);       // store at 0000, HL wraps to FFFF
        issue(OP_LDD_HLA, 16'h0000);       // store at FFFF
        issue(OP_LD_SP, 16'hFFFF);
        issue(OP_LD_SP, 16'h0000);
        issue(OP_EI, 16'h0000);
        issue(OP_EI, 16'hFFFF);            // enable twice: stays set
        issue(OP_DI, 16'h0000);
        issue(OP_XOR_A, 16'hFFFF);         // clears A, leaves only Z
        issue(OP_JP_A16, 16'h0000);

        // Random part: short programs, lone subset opcodes and raw noise.
        while (n_items < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            calm = ((n_items / 200) % 5) == 4;
            if (!drained && n_items > PRESSURE_POINT) begin
                drain_results();
                drained = 1'b1;
            end
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                issue(subset_ops[$urandom_range(0, 13)], 16'($urandom_range(0, 65535)));
            end else if (kind < 60) begin
                // Countdown loop: load a small count, then DEC / JR NZ until zero.
                cnt    = 8'($urandom_range(1, 5));
                hi8    = 8'($urandom_range(0, 255));
                ld_op  = $urandom_range(0, 1) ? OP_LD_B : OP_LD_C;
                dec_op = (ld_op == OP_LD_B) ? OP_DEC_B : OP_DEC_C;
                issue(ld_op, {hi8, cnt});
                repeat (cnt) begin
                    issue(dec_op, 16'($urandom_range(0, 65535)));
                    issue(OP_JR_NZ, 16'($urandom_range(0, 65535)));
                end
            end else if (kind < 80) begin
                // Store burst down from HL, often right at the bottom of memory.
                hl_start = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 2))
                                                       : 16'($urandom_range(0, 65535));
                bursts   = $urandom_range(1, 4);
                issue(OP_LD_HL, hl_start);
                issue(OP_LD_A, 16'($urandom_range(0, 65535)));
                repeat (bursts) issue(OP_LDD_HLA, 16'($urandom_range(0, 65535)));
            end else begin
                issue(8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)));
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d instruction beats (%0d outside the subset), random gaps and stalls.",
                 n_items, n_unsupported);
        $display("Compared %0d result beats field by field, %0d mismatches.",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: sm83_instruction_subset_step.f
rtl/sm83s_pkg.sv
rtl/sm83_instruction_subset_step.sv
rtl/sm83s_checker.sv
bench/sm83s_checker.sv
bench/tb_top.sv
